/* rtl/csa_pkg.sv */
// Package for the chunklet scatter accumulator: sizes, request codes and
// the cell handoff type. No dependencies.
package csa_pkg;

	localparam int DIMS = 8;
	localparam int GROUPS = 16;
	localparam int COUNT_BITS = 16;
	localparam int DIM_W = 3;
	localparam int GRP_W = 4;
	localparam int ACC_W = 48;
	localparam int DIFF_W = 17;
	localparam int PROD_W = 34;
	localparam int MEAN_DEPTH = GROUPS * DIMS;
	localparam int MEAN_AW = $clog2(MEAN_DEPTH);

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_READ = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// One step handed down the chain of cells.
	typedef struct packed {
		logic                     en;
		logic                     clr;
		logic signed [DIFF_W-1:0] row_diff;
	} cell_ctl_t;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

/* rtl/chunklet_scatter_accumulator.sv */
// Chunklet scatter accumulator: builds the within-group scatter matrix from
// sample rows and returns entries divided by the row count. Uses csa_pkg,
// csa_cell and csa_divider.
//
// One request is taken at a time. A clear walks down the chain of DIMS
// column cells. A row end feeds one row step per cycle into the chain. A
// read runs a restoring divider, one quotient bit per cycle. The result is
// held in an output register, and the next input transfer can be taken in
// the cycle after the result transfer.
module chunklet_scatter_accumulator
	import csa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [GRP_W-1:0]   group_id,
	input  logic [DIM_W-1:0]   dim_index,
	input  logic [DIM_W-1:0]   col_index,
	input  logic signed [15:0] value,
	input  logic               row_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] entry_value,
	output logic               read_valid,
	output logic               saturated
);

	localparam int STEP_W = $clog2(2 * DIMS + 1);

	state_t state_q, state_d;
	req_t req_q;
	logic [GRP_W-1:0] grp_q;
	logic [DIM_W-1:0] dim_q, col_q;
	logic signed [15:0] val_q;
	logic last_q;
	logic [STEP_W-1:0] step_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [15:0] mean_mem [MEAN_DEPTH];
	logic signed [15:0] mean_rd_s1;
	logic [MEAN_AW-1:0] mean_addr;
	logic grp_ok;

	logic accept, work_done, div_start, div_done, div_clamp;
	logic signed [31:0] div_quo;
	logic signed [ACC_W-1:0] rd_entry_q;

	cell_ctl_t ctl [DIMS+1];
	logic signed [DIFF_W-1:0] diffs [DIMS];
	logic signed [ACC_W-1:0] rd_cols [DIMS];
	logic [DIMS-1:0] diff_we;
	logic diff_clr;
	logic signed [DIFF_W-1:0] diff_wdata;

	assign accept = in_valid && in_ready;
	assign grp_ok = {1'b0, grp_q} < (GRP_W+1)'(GROUPS);
	assign mean_addr = MEAN_AW'({grp_q, dim_q});

	always_ff @(posedge clk) begin
		if (state_q == ST_ACCUM && step_q == '0 && req_q == REQ_LOAD
			&& grp_ok && {1'b0, dim_q} < (DIM_W+1)'(DIMS))
			mean_mem[mean_addr] <= val_q;
		mean_rd_s1 <= mean_mem[mean_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
			req_q <= REQ_LOAD;
			grp_q <= '0;
			dim_q <= '0;
			col_q <= '0;
			val_q <= '0;
			last_q <= 1'b0;
			rd_entry_q <= '0;
			read_valid <= 1'b0;
			entry_value <= '0;
			saturated <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				req_q <= req_t'(req_type);
				grp_q <= group_id;
				dim_q <= dim_index;
				col_q <= col_index;
				val_q <= value;
				last_q <= row_end;
				step_q <= '0;
			end else if (state_q == ST_ACCUM) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == ST_ACCUM && step_q == '0) begin
				if (req_q == REQ_CLEAR) count_q <= '0;
				if (req_q == REQ_READ) rd_entry_q <= rd_cols[col_q];
			end
			if (state_q == ST_ACCUM && req_q == REQ_SAMPLE && last_q
				&& step_q == STEP_W'(1) && count_q != '1)
				count_q <= count_q + 1'b1;
			if (state_q == ST_DONE) begin
				out_valid <= 1'b1;
				read_valid <= req_q == REQ_READ;
				entry_value <= '0;
				saturated <= 1'b0;
				if (req_q == REQ_READ && {1'b0, dim_q} < (DIM_W+1)'(DIMS)
					&& {1'b0, col_q} < (DIM_W+1)'(DIMS)) begin
					entry_value <= count_q == '0 ? '0 : div_quo;
					saturated <= (count_q != '0 && div_clamp) || count_q == '1
						|| rd_entry_q == ACC_MAX || rd_entry_q == ACC_MIN;
				end
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Step 0 reads the mean; step 1 writes diff; a row end then feeds rows.
	always_comb begin
		work_done = 1'b0;
		unique case (req_q)
			REQ_SAMPLE: work_done = last_q ? step_q == STEP_W'(2 * DIMS + 1)
				: step_q == STEP_W'(1);
			REQ_CLEAR: work_done = step_q == STEP_W'(DIMS - 1);
			REQ_READ: work_done = step_q == STEP_W'(1);
			default: work_done = step_q == '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_ACCUM;
			ST_ACCUM: if (work_done)
				state_d = req_q == REQ_READ ? ST_DIVIDE : ST_DONE;
			ST_DIVIDE: if (div_done) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == ST_IDLE && !out_valid;
		div_start = state_q == ST_ACCUM && req_q == REQ_READ && step_q == STEP_W'(1);
		diff_clr = 1'b0;
		diff_we = '0;
		diff_wdata = DIFF_W'($signed(val_q)) - (grp_ok ? DIFF_W'(mean_rd_s1) : '0);
		ctl[0] = '0;
		if (state_q == ST_ACCUM && req_q == REQ_CLEAR) ctl[0].clr = 1'b1;
		if (state_q == ST_ACCUM && req_q == REQ_SAMPLE) begin
			if (step_q == STEP_W'(1) && {1'b0, dim_q} < (DIM_W+1)'(DIMS))
				diff_we[dim_q] = 1'b1;
			if (last_q && step_q >= STEP_W'(2) && step_q < STEP_W'(2 + DIMS)) begin
				ctl[0].en = 1'b1;
				ctl[0].row_diff = diffs[DIM_W'(step_q - STEP_W'(2))];
			end
			if (last_q && step_q == STEP_W'(2 * DIMS + 1)) diff_clr = 1'b1;
		end
	end

	// Row steps reach cell k through the control registers of cells 0 to k-1, so its row select is offset by k.
	genvar k;
	for (k = 0; k < DIMS; k++) begin : g_cell
		logic [DIM_W-1:0] row_sel;
		assign row_sel = DIM_W'(step_q - STEP_W'(2) - STEP_W'(k));
		csa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ctl[k]),
			.row_sel   (row_sel),
			.diff_we   (diff_we[k]),
			.diff_clr  (diff_clr),
			.diff_wdata(diff_wdata),
			.rd_row    (dim_q),
			.ctl_out   (ctl[k+1]),
			.diff      (diffs[k]),
			.rd_data   (rd_cols[k])
		);
	end

	csa_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(rd_entry_q),
		.divisor (count_q),
		.done    (div_done),
		.quotient(div_quo),
		.clamped (div_clamp)
	);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> out_valid) else $error("result not posted");
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> entry_value == '0 && !saturated)
		else $error("non-read result carries data");

endmodule

/* rtl/csa_cell.sv */
// One column cell of the accumulator chain: holds one column of the scatter
// matrix and multiplies its own diff by the row diff. Uses csa_pkg.
module csa_cell
	import csa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl_in,
	input  logic [DIM_W-1:0]         row_sel,
	input  logic                     diff_we,
	input  logic                     diff_clr,
	input  logic signed [DIFF_W-1:0] diff_wdata,
	input  logic [DIM_W-1:0]         rd_row,
	output cell_ctl_t                ctl_out,
	output logic signed [DIFF_W-1:0] diff,
	output logic signed [ACC_W-1:0]  rd_data
);

	logic signed [DIFF_W-1:0] diff_q;
	logic signed [ACC_W-1:0] acc_q [DIMS];
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W:0] sum;

	assign prod = ctl_in.row_diff * diff_q;
	assign sum = {acc_q[row_sel][ACC_W-1], acc_q[row_sel]}
		+ {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
			ctl_out <= '0;
			for (int i = 0; i < DIMS; i++) acc_q[i] <= '0;
		end else begin
			ctl_out <= ctl_in;
			if (diff_clr) diff_q <= '0;
			else if (diff_we) diff_q <= diff_wdata;
			if (ctl_in.clr) begin
				for (int i = 0; i < DIMS; i++) acc_q[i] <= '0;
			end else if (ctl_in.en) begin
				if (sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) acc_q[row_sel] <= ACC_MAX;
				else if (sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) acc_q[row_sel] <= ACC_MIN;
				else acc_q[row_sel] <= sum[ACC_W-1:0];
			end
		end
	end

	assign diff = diff_q;
	assign rd_data = acc_q[rd_row];

endmodule

/* rtl/csa_divider.sv */
// Restoring divider, one quotient bit per cycle, with signed fixup and
// 32-bit saturation. Uses csa_pkg.
module csa_divider
	import csa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] dividend,
	input  logic [COUNT_BITS-1:0]   divisor,
	output logic                    done,
	output logic signed [31:0]      quotient,
	output logic                    clamped
);

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] quo_q;
	logic [COUNT_BITS:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic neg_q, busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [COUNT_BITS:0] shifted;
	logic [ACC_W:0] sq;

	assign shifted = {rem_q[COUNT_BITS-1:0], quo_q[ACC_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ACC_W);
				neg_q <= dividend[ACC_W-1];
				quo_q <= dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
				rem_q <= '0;
				den_q <= divisor;
			end else if (busy_q) begin
				if (shifted >= {1'b0, den_q}) begin
					rem_q <= shifted - {1'b0, den_q};
					quo_q <= {quo_q[ACC_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[ACC_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		sq = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		clamped = 1'b0;
		quotient = sq[31:0];
		if ($signed(sq) > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}})) begin
			quotient = 32'h7fff_ffff;
			clamped = 1'b1;
		end else if ($signed(sq) < $signed({{(ACC_W-31){1'b1}}, 1'b1, 31'd0}) ) begin
			quotient = 32'h8000_0000;
			clamped = 1'b1;
		end
	end

endmodule

/* tb/testbench.sv */
// Testbench for chunklet_scatter_accumulator: drives mean loads, sample rows,
// reads and clears, and checks every response against a scatter-matrix predictor.
// Depends on csa_pkg and the chunklet_scatter_accumulator RTL.
module testbench;
	import csa_pkg::*;

	typedef struct {
		logic signed [31:0] entry;
		logic               rd;
		logic               sat;
	} resp_t;

	class scatter_scoreboard;
		logic signed [15:0] means [MEAN_DEPTH];
		logic signed [16:0] diffs [DIMS];
		logic signed [47:0] scatter [DIMS*DIMS];
		logic [COUNT_BITS-1:0] rows;
		resp_t pending [$];
		int errors;
		int reads;
		int row_ends;

		function new();
			for (int i = 0; i < MEAN_DEPTH; i++) means[i] = 0;
			for (int i = 0; i < DIMS; i++) diffs[i] = 0;
			for (int i = 0; i < DIMS*DIMS; i++) scatter[i] = 0;
			rows = 0;
			errors = 0;
			reads = 0;
			row_ends = 0;
		endfunction

		function void note_request(req_t rq, int grp, int dim, int col,
				logic signed [15:0] val, logic last);
			resp_t r;
			longint a, q, s, cnt, amax, amin;
			amax = 64'sd140737488355327;
			amin = -amax - 1;
			r.entry = 0;
			r.rd = 0;
			r.sat = 0;
			cnt = rows;
			case (rq)
				REQ_LOAD: begin
					if (grp < GROUPS && dim < DIMS) means[grp*DIMS+dim] = val;
				end
				REQ_SAMPLE: begin
					if (dim < DIMS)
						diffs[dim] = 17'(val)
							- 17'((grp < GROUPS) ? means[grp*DIMS+dim] : 16'sd0);
					if (last) begin
						row_ends++;
						for (int i = 0; i < DIMS; i++)
							for (int j = 0; j < DIMS; j++) begin
								s = longint'(scatter[i*DIMS+j])
									+ longint'(diffs[i]) * longint'(diffs[j]);
								if (s > amax) s = amax;
								if (s < amin) s = amin;
								scatter[i*DIMS+j] = 48'(s);
							end
						for (int i = 0; i < DIMS; i++) diffs[i] = 0;
						if (rows != {COUNT_BITS{1'b1}}) rows++;
					end
				end
				REQ_READ: begin
					r.rd = 1;
					reads++;
					if (dim < DIMS && col < DIMS) begin
						a = scatter[dim*DIMS+col];
						q = (cnt != 0) ? a / cnt : 0;
						if (q > 64'sd2147483647) begin
							q = 64'sd2147483647;
							r.sat = 1;
						end else if (q < -64'sd2147483648) begin
							q = -64'sd2147483648;
							r.sat = 1;
						end
						if (a == amax || a == amin || rows == {COUNT_BITS{1'b1}}) r.sat = 1;
						r.entry = q[31:0];
					end
				end
				default: begin
					for (int i = 0; i < DIMS*DIMS; i++) scatter[i] = 0;
					rows = 0;
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_response(logic signed [31:0] e, logic rd, logic sat);
			resp_t x;
			if (pending.size() == 0) begin
				$error("response with nothing expected");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (e !== x.entry) begin
				$error("entry_value expected %0d actual %0d", x.entry, e);
				errors++;
			end
			if (rd !== x.rd) begin
				$error("read_valid expected %0b actual %0b", x.rd, rd);
				errors++;
			end
			if (sat !== x.sat) begin
				$error("saturated expected %0b actual %0b", x.sat, sat);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] req_type = 0;
	logic [GRP_W-1:0] group_id = 0;
	logic [DIM_W-1:0] dim_index = 0;
	logic [DIM_W-1:0] col_index = 0;
	logic signed [15:0] value = 0;
	logic row_end = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] entry_value;
	logic read_valid;
	logic saturated;

	scatter_scoreboard sb = new();
	longint cycles = 0;
	bit loaded [MEAN_DEPTH];
	bit sending_done = 0;

	chunklet_scatter_accumulator dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_response(entry_value, read_valid, saturated);
	end

	initial begin
		int g;
		@(posedge clk);
		while (!sending_done || sb.pending.size() != 0) begin
			g = gap_len();
			out_ready <= (g == 0) || ($urandom_range(0, 3) == 0);
			@(posedge clk);
			if (g > 0) repeat (g) begin
				out_ready <= 0;
				@(posedge clk);
			end
		end
		out_ready <= 1;
	end

	// Valid stays high between back-to-back transfers and drops only for a gap.
	task automatic send(req_t rq, int grp, int dim, int col, logic signed [15:0] val, logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= rq;
		group_id <= GRP_W'(grp);
		dim_index <= DIM_W'(dim);
		col_index <= DIM_W'(col);
		value <= val;
		row_end <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rq, grp, dim, col, val, last);
		if (rq == REQ_LOAD && grp < GROUPS && dim < DIMS) loaded[grp*DIMS+dim] = 1;
	endtask

	// A sample of a group/dim whose mean was never loaded is preceded by a load of a random mean.
	task automatic send_sample(int grp, int dim, logic signed [15:0] val, logic last);
		if (grp < GROUPS && dim < DIMS && !loaded[grp*DIMS+dim])
			send(REQ_LOAD, grp, dim, 0, 16'($urandom()), 0);
		send(REQ_SAMPLE, grp, dim, 0, val, last);
	endtask

	task automatic send_row(int grp, int extreme);
		logic signed [15:0] v;
		for (int d = 0; d < DIMS; d++) begin
			v = extreme ? (($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000) : 16'($urandom());
			send_sample(grp, d, v, d == DIMS - 1);
		end
	endtask

	initial begin
		int k, n, p;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, empty read, saturation.
		send(REQ_READ, 0, 0, 0, 0, 0);
		for (int d = 0; d < DIMS; d++) send(REQ_LOAD, 0, d, 0, 16'sh8000, 0);
		send(REQ_LOAD, 15, 7, 0, 16'sh7fff, 1);
		for (int d = 0; d < DIMS; d++) send_sample(0, d, 16'sh7fff, d == DIMS - 1);
		send(REQ_READ, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 7, 3, 0, 0);
		send_sample(0, 2, 16'sh8000, 1);
		send(REQ_READ, 0, 2, 2, 0, 0);
		send(REQ_READ, 0, 0, 7, 0, 1);
		send(REQ_CLEAR, 0, 0, 0, 0, 1);
		send(REQ_READ, 0, 0, 0, 0, 0);
		send_row(15, 1);
		send(REQ_READ, 15, 7, 7, 0, 0);

		// Sender holds off until the block has answered everything.
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);

		n = 0;
		while (n < 1150) begin
			p = $urandom_range(0, 99);
			if (p < 45) begin
				send_row($urandom_range(0, 15), $urandom_range(0, 9) == 0);
				n += DIMS;
			end else if (p < 60) begin
				send(REQ_LOAD, $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
					16'($urandom()), $urandom_range(0, 1));
				n++;
			end else if (p < 70) begin
				send_sample($urandom_range(0, 15), $urandom_range(0, 7),
					16'($urandom()), $urandom_range(0, 1));
				n++;
			end else if (p < 97) begin
				k = $urandom_range(1, 4);
				repeat (k) send(REQ_READ, $urandom_range(0, 15), $urandom_range(0, 7),
					$urandom_range(0, 7), 16'($urandom()), $urandom_range(0, 1));
				n += k;
			end else begin
				send(REQ_CLEAR, $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
					16'($urandom()), $urandom_range(0, 1));
				n++;
			end
		end
		in_valid <= 0;
		sending_done = 1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d row ends and %0d reads, with random stalls on both channels.",
			sb.row_ends, sb.reads);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
rtl/csa_pkg.sv
rtl/csa_cell.sv
rtl/csa_divider.sv
rtl/chunklet_scatter_accumulator.sv
tb/testbench.sv
